[hdl/icd_pkg.sv]
// Shared types, constants and helpers of the interleaved channel demux.
// No dependencies; used by every module of the block.
package icd_pkg;

    localparam int CH_W        = 3;
    localparam int NUM_W       = 4;
    localparam int MAX_CH      = 8;
    localparam int POS_W       = 12;
    localparam int BYTE_W      = 8;
    localparam int MAP_W       = 24;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_DATA_W   = 8;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 24;
    localparam int QUEUE_DEPTH = 4;
    localparam int BLOCK_BYTES_DEFAULT = 4096;

    localparam logic [NUM_W-1:0]  NUM_CHANNELS_RESET = 4'd2;
    localparam logic [MAP_W-1:0]  CHANNEL_MAP_RESET  = 24'd16434824;
    localparam logic [BYTE_W-1:0] IDLE_VALUE_RESET   = 8'd105;
    localparam logic              PAD_TO_BLOCK_RESET = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_CHANNELS = 2'd0,
        REG_CHANNEL_MAP  = 2'd1,
        REG_IDLE_VALUE   = 2'd2,
        REG_PAD_TO_BLOCK = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        OP_DATA = 1'b0,
        OP_PAD  = 1'b1
    } op_t;

    typedef struct packed {
        logic [NUM_W-1:0]  num_channels;
        logic [MAP_W-1:0]  channel_map;
        logic [BYTE_W-1:0] idle_value;
        logic              pad_to_block;
    } cfg_t;

    // One queued job: a single data result, or a pad run over mapped sources.
    typedef struct packed {
        logic              is_pad;
        logic [CH_W-1:0]   chan;
        logic [POS_W-1:0]  pos;
        logic [BYTE_W-1:0] value;
        logic [MAX_CH-1:0] mask;
    } cmd_t;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic [POS_W-1:0]  pos;
        logic [CH_W-1:0]   chan;
    } res_t;

    // Effective channel count: 0 acts as 1, above 8 acts as 8.
    function automatic logic [NUM_W-1:0] chan_count(input logic [NUM_W-1:0] num);
        logic [NUM_W-1:0] n;
        begin
            n = num;
            if (num == '0)
            begin
                n = NUM_W'(1);
            end
            else if (num > NUM_W'(MAX_CH))
            begin
                n = NUM_W'(MAX_CH);
            end
            return n;
        end
    endfunction

    function automatic logic [CH_W-1:0] dest_of(input logic [MAP_W-1:0] map,
                                                input logic [CH_W-1:0] k);
        return map[k*CH_W +: CH_W];
    endfunction

endpackage

[hdl/icd_front.sv]
// Front end: takes input transfers, tracks source channel and frame position,
// and turns each accepted item that yields output into a queued job. Depends on icd_pkg.
module icd_front #(
    parameter int BLOCK_BYTES = icd_pkg::BLOCK_BYTES_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  icd_pkg::cfg_t                  cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [icd_pkg::BYTE_W-1:0]     in_byte,
    input  logic                           in_op,
    input  logic                           in_first,
    input  logic                           queue_full,
    output logic                           push,
    output icd_pkg::cmd_t                  push_cmd
);

    localparam int FP_W = $clog2(BLOCK_BYTES + 1);

    logic [icd_pkg::CH_W-1:0]   sc_reg, sc_next;
    logic [FP_W-1:0]            fp_reg, fp_next;
    logic [icd_pkg::NUM_W-1:0]  n;
    logic [icd_pkg::CH_W-1:0]   sc;
    logic [FP_W-1:0]            fp;
    logic [icd_pkg::NUM_W-1:0]  sc_inc;
    logic [icd_pkg::CH_W-1:0]   dest;
    logic [icd_pkg::MAX_CH-1:0] pad_mask;
    logic                       block_full;
    logic                       accept;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign n        = icd_pkg::chan_count(cfg.num_channels);

    always_comb
    begin
        sc = in_first ? '0 : sc_reg;
        fp = in_first ? '0 : fp_reg;
        if ({1'b0, sc} >= n)
        begin
            sc = '0;
        end
    end

    assign block_full = (fp >= FP_W'(BLOCK_BYTES));
    assign sc_inc     = {1'b0, sc} + icd_pkg::NUM_W'(1);
    assign dest       = icd_pkg::dest_of(cfg.channel_map, sc);

    always_comb
    begin
        for (int k = 0; k < icd_pkg::MAX_CH; k++)
        begin
            pad_mask[k] = (icd_pkg::NUM_W'(k) < n) &&
                ({1'b0, icd_pkg::dest_of(cfg.channel_map, icd_pkg::CH_W'(k))} < n);
        end
    end

    always_comb
    begin
        sc_next         = sc_reg;
        fp_next         = fp_reg;
        push            = 1'b0;
        push_cmd.is_pad = 1'b0;
        push_cmd.chan   = dest;
        push_cmd.pos    = icd_pkg::POS_W'(fp);
        push_cmd.value  = in_byte;
        push_cmd.mask   = pad_mask;
        if (accept)
        begin
            // first and the channel wrap take effect even when nothing is emitted
            sc_next = sc;
            fp_next = fp;
            if (!block_full)
            begin
                if (in_op == icd_pkg::OP_DATA)
                begin
                    push = ({1'b0, dest} < n);
                    if (sc_inc >= n)
                    begin
                        sc_next = '0;
                        fp_next = fp + FP_W'(1);
                    end
                    else
                    begin
                        sc_next = sc_inc[icd_pkg::CH_W-1:0];
                    end
                end
                else if (cfg.pad_to_block)
                begin
                    push_cmd.is_pad = 1'b1;
                    push            = (pad_mask != '0);
                    sc_next         = '0;
                    fp_next         = fp + FP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_reg <= '0;
            fp_reg <= '0;
        end
        else
        begin
            sc_reg <= sc_next;
            fp_reg <= fp_next;
        end
    end

endmodule

[hdl/icd_queue.sv]
// Short job queue between front end and back end, flip-flop storage.
// Depends on icd_pkg.
module icd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  icd_pkg::cmd_t push_cmd,
    output logic          full,
    output logic          head_valid,
    output icd_pkg::cmd_t head_cmd,
    input  logic          pop
);

    localparam int PTR_W = $clog2(icd_pkg::QUEUE_DEPTH);

    icd_pkg::cmd_t    slot_reg [icd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    assign full       = (count_reg == (PTR_W+1)'(icd_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hdl/icd_back.sv]
// Back end (uses icd_pkg): expands queued jobs into output-register results,
// one per cycle unless stalled. Pad runs walk the source mask lowest bit first.
module icd_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  icd_pkg::cfg_t              cfg,
    input  logic                       head_valid,
    input  icd_pkg::cmd_t              head_cmd,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output icd_pkg::res_t              out_res,
    output logic                       out_last
);

    logic                       busy_reg, busy_next;
    logic [icd_pkg::MAX_CH-1:0] rem_reg, rem_next;
    logic                       valid_reg, valid_next;
    icd_pkg::res_t              res_reg, res_next;
    logic                       last_reg, last_next;
    logic [icd_pkg::MAX_CH-1:0] mask;
    logic [icd_pkg::MAX_CH-1:0] rest;
    logic [icd_pkg::CH_W-1:0]   low_k;
    logic                       load;

    assign load = head_valid && (!valid_reg || out_ready);
    assign mask = busy_reg ? rem_reg : head_cmd.mask;

    always_comb
    begin
        low_k = '0;
        for (int k = icd_pkg::MAX_CH - 1; k >= 0; k--)
        begin
            if (mask[k])
            begin
                low_k = icd_pkg::CH_W'(k);
            end
        end
    end

    assign rest = mask & ~(icd_pkg::MAX_CH'(1) << low_k);

    always_comb
    begin
        busy_next  = busy_reg;
        rem_next   = rem_reg;
        res_next   = res_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        valid_next = valid_reg && !out_ready;
        if (load)
        begin
            valid_next   = 1'b1;
            res_next.pos = head_cmd.pos;
            if (head_cmd.is_pad)
            begin
                res_next.chan  = icd_pkg::dest_of(cfg.channel_map, low_k);
                res_next.value = cfg.idle_value;
                last_next      = (rest == '0);
                pop            = (rest == '0);
                busy_next      = (rest != '0);
                rem_next       = rest;
            end
            else
            begin
                res_next.chan  = head_cmd.chan;
                res_next.value = head_cmd.value;
                last_next      = 1'b1;
                pop            = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        last_reg <= last_next;
        rem_reg  <= rem_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            busy_reg  <= busy_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;
    assign out_last  = last_reg;

endmodule

[hdl/interleaved_channel_demux_unit.sv]
// Interleaved channel demux, top level.
// Input stream: one frame-interleaved byte or pad command per transfer.
//   s_axis_tdata carries the byte, s_axis_tuser the op and first flags.
// Output stream: one (channel, position, value) result per transfer, tlast on
//   a data result and on the final result of a pad run.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; always
//   ready. The user must write it only while the block is idle; not enforced.
// Throughput: one input transfer per clock while the job queue has room.
//   A data byte gives at most one result, a pad item up to the effective
//   channel count of results, emitted one per clock by the back end unless stalled.
// Path: with the queue empty, a result reaches m_axis through the queue
//   storage (written at the transfer edge) and then the output register.
// Reset clears counters, queue and output register, and loads the register
//   defaults (2 channels, idle byte 0x69, padding on). No reset sweep.
// When the receiver stalls, the result holds in the output register, the
//   queue fills, and s_axis_tready drops once four jobs wait.
// Depends on icd_pkg, icd_front, icd_queue, icd_back.
module interleaved_channel_demux_unit #(
    parameter int BLOCK_BYTES = icd_pkg::BLOCK_BYTES_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [icd_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [7:0] data_byte
    input  logic [icd_pkg::IN_USER_W-1:0]     s_axis_tuser,  // [0] op, [1] first
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [icd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // [2:0] channel,
                                                             // [14:3] position,
                                                             // [22:15] value, [23] 0
    output logic                              m_axis_tlast,  // last
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [icd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [icd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    icd_pkg::cfg_t cfg_reg, cfg_next;
    logic          push;
    icd_pkg::cmd_t push_cmd;
    logic          queue_full;
    logic          head_valid;
    icd_pkg::cmd_t head_cmd;
    logic          pop;
    icd_pkg::res_t res;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (icd_pkg::cfg_idx_t'(cfg_index))
                icd_pkg::REG_NUM_CHANNELS:
                    cfg_next.num_channels = cfg_data[icd_pkg::NUM_W-1:0];
                icd_pkg::REG_CHANNEL_MAP:
                    cfg_next.channel_map  = cfg_data[icd_pkg::MAP_W-1:0];
                icd_pkg::REG_IDLE_VALUE:
                    cfg_next.idle_value   = cfg_data[icd_pkg::BYTE_W-1:0];
                icd_pkg::REG_PAD_TO_BLOCK:
                    cfg_next.pad_to_block = cfg_data[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_channels <= icd_pkg::NUM_CHANNELS_RESET;
            cfg_reg.channel_map  <= icd_pkg::CHANNEL_MAP_RESET;
            cfg_reg.idle_value   <= icd_pkg::IDLE_VALUE_RESET;
            cfg_reg.pad_to_block <= icd_pkg::PAD_TO_BLOCK_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    icd_front #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .in_op      (s_axis_tuser[0]),
        .in_first   (s_axis_tuser[1]),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    icd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop)
    );

    icd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_res    (res),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, res.value, res.pos, res.chan};

endmodule

[hdl/icd_checker.sv]
// Port-level checks for the interleaved channel demux, bound to the top level.
// Depends on icd_pkg and interleaved_channel_demux_unit.
module icd_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [icd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tlast,
    input logic                           cfg_valid,
    input logic                           cfg_ready
);

    // a stalled result must hold until its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("output result changed while stalled");

    a_pad_bit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[icd_pkg::OUT_DATA_W-1] == 1'b0))
        else $error("output padding bit set");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

    // queue and output register come out of reset empty
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> (!m_axis_tvalid && s_axis_tready))
        else $error("block not empty after reset");

endmodule

bind interleaved_channel_demux_unit icd_checker u_icd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready)
);
